// ===== hw/rtl/ascrm_pkg.sv =====
// shared types and constants for the audio sof clock ratio meter
// used by the serial divider, the serial multiplier and the top level

package ascrm_pkg;

    // serial datapath widths
    localparam int DivWidth = 33;
    localparam int DivCntW  = 6;
    localparam int MulWidth = 32;
    localparam int MulCntW  = 5;

    // configuration field widths and reset values
    localparam int TfWidth = 25;
    localparam int SrWidth = 19;
    localparam logic [TfWidth-1:0] TfReset = 25'd1000;

    // timer ticks per millisecond divisor, all-ones dividend for reciprocals
    localparam logic [DivWidth-1:0] MsDivisor = 33'd1000;
    localparam logic [DivWidth-1:0] RecipOnes = 33'h0_FFFF_FFFF;

    // register select, from paddr bit 2
    typedef enum logic {
        REG_TIMER_FREQ = 1'b0,
        REG_SAMPLE_RATE = 1'b1
    } reg_sel_t;

    // sequencer states, one-hot
    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_FDIV  = 9'b000000010,
        ST_WDIV  = 9'b000000100,
        ST_MWDIV = 9'b000001000,
        ST_MFDIV = 9'b000010000,
        ST_MUL0  = 9'b000100000,
        ST_MUL1  = 9'b001000000,
        ST_MUL2  = 9'b010000000,
        ST_DONE  = 9'b100000000
    } state_t;

endpackage

// ===== hw/rtl/ascrm_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
// depends on ascrm_pkg for its width

module ascrm_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [ascrm_pkg::DivWidth-1:0]  dividend,
    input  logic [ascrm_pkg::DivWidth-1:0]  divisor,
    output logic [ascrm_pkg::DivWidth-1:0]  quotient,
    output logic                            done
);
    import ascrm_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [DivCntW-1:0]  cnt_reg, cnt_next;
    logic [DivWidth-1:0] quo_reg, quo_next;
    logic [DivWidth-1:0] rem_reg, rem_next;
    logic [DivWidth-1:0] dvs_reg, dvs_next;
    logic [DivWidth:0]   trial;
    logic [DivWidth:0]   diff;
    logic                ge;

    // one restoring step
    always_comb
    begin
        trial = {rem_reg, quo_reg[DivWidth-1]};
        diff  = trial - {1'b0, dvs_reg};
        ge    = (trial >= {1'b0, dvs_reg});
    end

    // control
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DivCntW'(DivWidth - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // datapath
    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DivWidth-2:0], ge};
            rem_next = ge ? diff[DivWidth-1:0] : trial[DivWidth-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ===== hw/rtl/ascrm_mul.sv =====
// bit-serial shift-add multiplier, one multiplier bit per cycle
// depends on ascrm_pkg for its width

module ascrm_mul (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [ascrm_pkg::MulWidth-1:0]    a,
    input  logic [ascrm_pkg::MulWidth-1:0]    b,
    output logic [2*ascrm_pkg::MulWidth-1:0]  product,
    output logic                              done
);
    import ascrm_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [MulCntW-1:0]  cnt_reg, cnt_next;
    logic [MulWidth-1:0] a_reg, a_next;
    logic [MulWidth-1:0] hi_reg, hi_next;
    logic [MulWidth-1:0] lo_reg, lo_next;
    logic [MulWidth:0]   sum;

    // partial sum for the current multiplier bit
    assign sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : '0);

    // control
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == MulCntW'(MulWidth - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // datapath
    always_comb
    begin
        a_next  = a_reg;
        hi_next = hi_reg;
        lo_next = lo_reg;
        if (start)
        begin
            a_next  = a;
            hi_next = '0;
            lo_next = b;
        end
        else if (busy_reg)
        begin
            hi_next = sum[MulWidth:1];
            lo_next = {sum[0], lo_reg[MulWidth-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg  <= a_next;
        hi_reg <= hi_next;
        lo_reg <= lo_next;
    end

    assign product = {hi_reg, lo_reg};
    assign done    = done_reg;

endmodule

// ===== hw/rtl/audio_sof_clock_ratio_meter.sv =====
// top level of the audio sof clock ratio meter
// depends on ascrm_pkg, ascrm_div and ascrm_mul
//
// Usage:
//   The input stream carries one beat per capture event: s_tdata holds the
//   word-select and start-of-frame timer captures, s_tuser the restart and
//   edge flags. Each accepted beat updates the two measured periods and
//   yields exactly one output beat with the clock ratio, both periods and
//   the high-speed flag.
//   The APB port sets the timer frequency (address 0) and the nominal
//   sample rate (address 4); write them only while no beat is in flight.
//   Each accepted beat runs four divisions and three multiplications in turn
//   on one shared bit-serial divider and one bit-serial multiplier, and
//   then loads the output register. One beat is worked on at a time: a new
//   beat is taken only once the last result is loaded. s_tready rises again
//   as soon as the result sits in the output register, so the next input
//   can be taken while it waits.
//   If m_tready stays low, the finished result holds and the following
//   computation stalls at its end until the output register is free.
//   Reset clears the periods, valid marks and output valid flag, and sets
//   the timer frequency to 1000 and the sample rate to 0.

module audio_sof_clock_ratio_meter #(
    parameter int CAPTURE_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // input beat
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // word_capture[15:0], frame_capture[31:16]
    input  logic [2:0]  s_tuser,    // restart[0], word_edge[1], frame_edge[2]
    // output beat
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // ratio[31:0], word_period[47:32], frame_period[63:48]
    output logic        m_tuser,    // high_speed[0]
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ascrm_pkg::*;

    localparam logic [63:0] CapMaskWide = (64'd1 << CAPTURE_WIDTH) - 64'd1;
    localparam logic [15:0] CapMask = (CAPTURE_WIDTH >= 16) ? 16'hFFFF : CapMaskWide[15:0];

    // configuration registers
    logic [TfWidth-1:0] tf_reg;
    logic [SrWidth-1:0] sr_reg;
    logic               cfg_wr;
    reg_sel_t           cfg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_sel = reg_sel_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tf_reg <= TfReset;
            sr_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_sel)
                REG_TIMER_FREQ:  tf_reg <= pwdata[TfWidth-1:0];
                REG_SAMPLE_RATE: sr_reg <= pwdata[SrWidth-1:0];
                default:         tf_reg <= tf_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            REG_TIMER_FREQ:  prdata = {{(32-TfWidth){1'b0}}, tf_reg};
            REG_SAMPLE_RATE: prdata = {{(32-SrWidth){1'b0}}, sr_reg};
            default:         prdata = '0;
        endcase
    end

    // input fields
    logic        in_restart, in_wedge, in_fedge, in_accept;
    logic [15:0] in_wcap, in_fcap;

    assign in_restart = s_tuser[0];
    assign in_wedge   = s_tuser[1];
    assign in_fedge   = s_tuser[2];
    assign in_wcap    = s_tdata[15:0] & CapMask;
    assign in_fcap    = s_tdata[31:16] & CapMask;
    assign in_accept  = s_tvalid && s_tready;

    // capture state
    logic [15:0] wlast_reg, wlast_next, wlen_reg, wlen_next;
    logic [15:0] flast_reg, flast_next, flen_reg, flen_next;
    logic        wseen_reg, wseen_next, fseen_reg, fseen_next;

    always_comb
    begin
        wlast_next = wlast_reg;
        wlen_next  = wlen_reg;
        wseen_next = wseen_reg;
        flast_next = flast_reg;
        flen_next  = flen_reg;
        fseen_next = fseen_reg;
        if (in_accept)
        begin
            if (in_restart)
            begin
                wlen_next  = '0;
                flen_next  = '0;
                wseen_next = 1'b0;
                fseen_next = 1'b0;
            end
            if (in_wedge)
            begin
                if (wseen_next)
                    wlen_next = (in_wcap - wlast_reg) & CapMask;
                wlast_next = in_wcap;
                wseen_next = 1'b1;
            end
            if (in_fedge)
            begin
                if (fseen_next)
                    flen_next = (in_fcap - flast_reg) & CapMask;
                flast_next = in_fcap;
                fseen_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlast_reg <= '0;
            wlen_reg  <= '0;
            wseen_reg <= 1'b0;
            flast_reg <= '0;
            flen_reg  <= '0;
            fseen_reg <= 1'b0;
        end
        else
        begin
            wlast_reg <= wlast_next;
            wlen_reg  <= wlen_next;
            wseen_reg <= wseen_next;
            flast_reg <= flast_next;
            flen_reg  <= flen_next;
            fseen_reg <= fseen_next;
        end
    end

    // shared serial units
    logic                  div_start, div_done;
    logic [DivWidth-1:0]   div_dividend, div_divisor, div_quo;
    logic                  mul_start, mul_done;
    logic [MulWidth-1:0]   mul_a, mul_b;
    logic [2*MulWidth-1:0] mul_prod;

    ascrm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quo),
        .done     (div_done)
    );

    ascrm_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .product (mul_prod),
        .done    (mul_done)
    );

    // sequencer and intermediate registers
    state_t              state_reg, state_next;
    logic                dstart_reg, dstart_next, mstart_reg, mstart_next;
    logic                oval_reg, oval_next;
    logic [15:0]         expf_reg, expf_next;
    logic [DivWidth-1:0] expw_reg, expw_next;
    logic [31:0]         mulw_reg, mulw_next, mulf_reg, mulf_next;
    logic [31:0]         r_reg, r_next;
    logic [63:0]         odata_reg, odata_next;
    logic                ohs_reg, ohs_next;
    logic                frame_short, ratio_zero, out_free;
    logic [15:0]         expf_sel;

    assign frame_short = (flen_reg < (expf_reg >> 2));
    assign expf_sel    = frame_short ? (expf_reg >> 3) : expf_reg;
    assign ratio_zero  = (wlen_reg == '0) || (flen_reg == '0) || (sr_reg == '0)
                         || (expw_reg == '0);
    assign out_free    = !oval_reg || m_tready;

    // divider operands by step
    always_comb
    begin
        div_dividend = RecipOnes;
        div_divisor  = MsDivisor;
        unique case (state_reg)
            ST_FDIV:
            begin
                div_dividend = {{(DivWidth-TfWidth){1'b0}}, tf_reg};
            end
            ST_WDIV:
            begin
                div_dividend = {1'b0, tf_reg, 7'd0}
                               + {{(DivWidth-SrWidth+1){1'b0}}, sr_reg[SrWidth-1:1]};
                div_divisor  = {{(DivWidth-SrWidth){1'b0}}, sr_reg};
            end
            ST_MWDIV: div_divisor = expw_reg;
            ST_MFDIV: div_divisor = {{(DivWidth-16){1'b0}}, flen_reg};
            default:  div_divisor = MsDivisor;
        endcase
    end

    // multiplier operands by step
    always_comb
    begin
        mul_a = r_reg;
        mul_b = mulw_reg;
        unique case (state_reg)
            ST_MUL0:
            begin
                mul_a = {16'd0, wlen_reg};
                mul_b = {16'd0, expf_sel};
            end
            ST_MUL1: mul_b = mulf_reg;
            default: mul_b = mulw_reg;
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        dstart_next = 1'b0;
        mstart_next = 1'b0;
        oval_next   = oval_reg && !m_tready;
        expf_next   = expf_reg;
        expw_next   = expw_reg;
        mulw_next   = mulw_reg;
        mulf_next   = mulf_reg;
        r_next      = r_reg;
        odata_next  = odata_reg;
        ohs_next    = ohs_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next  = ST_FDIV;
                    dstart_next = 1'b1;
                end
            end
            ST_FDIV:
            begin
                if (div_done)
                begin
                    expf_next   = div_quo[15:0];
                    state_next  = ST_WDIV;
                    dstart_next = 1'b1;
                end
            end
            ST_WDIV:
            begin
                if (div_done)
                begin
                    expw_next   = div_quo;
                    state_next  = ST_MWDIV;
                    dstart_next = 1'b1;
                end
            end
            ST_MWDIV:
            begin
                if (div_done)
                begin
                    mulw_next   = div_quo[31:0];
                    state_next  = ST_MFDIV;
                    dstart_next = 1'b1;
                end
            end
            ST_MFDIV:
            begin
                if (div_done)
                begin
                    mulf_next   = div_quo[31:0];
                    state_next  = ST_MUL0;
                    mstart_next = 1'b1;
                end
            end
            ST_MUL0:
            begin
                if (mul_done)
                begin
                    r_next      = mul_prod[31:0];
                    state_next  = ST_MUL1;
                    mstart_next = 1'b1;
                end
            end
            ST_MUL1:
            begin
                if (mul_done)
                begin
                    r_next      = mul_prod[55:24];
                    state_next  = ST_MUL2;
                    mstart_next = 1'b1;
                end
            end
            ST_MUL2:
            begin
                if (mul_done)
                begin
                    r_next     = mul_prod[55:24];
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // load the output register once it is free
                if (out_free)
                begin
                    oval_next  = 1'b1;
                    odata_next = {flen_reg, wlen_reg, ratio_zero ? 32'd0 : r_reg};
                    ohs_next   = (flen_reg != '0) && frame_short;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            dstart_reg <= 1'b0;
            mstart_reg <= 1'b0;
            oval_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            dstart_reg <= dstart_next;
            mstart_reg <= mstart_next;
            oval_reg   <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        expf_reg  <= expf_next;
        expw_reg  <= expw_next;
        mulw_reg  <= mulw_next;
        mulf_reg  <= mulf_next;
        r_reg     <= r_next;
        odata_reg <= odata_next;
        ohs_reg   <= ohs_next;
    end

    assign div_start = dstart_reg;
    assign mul_start = mstart_reg;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = oval_reg;
    assign m_tdata   = odata_reg;
    assign m_tuser   = ohs_reg;

`ifndef SYNTHESIS
    a_div_done_in_div_step : assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_FDIV || state_reg == ST_WDIV
                      || state_reg == ST_MWDIV || state_reg == ST_MFDIV))
        else $error("divider finished outside a division step");

    a_mul_done_in_mul_step : assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == ST_MUL0 || state_reg == ST_MUL1
                      || state_reg == ST_MUL2))
        else $error("multiplier finished outside a multiply step");

    a_accept_starts_work : assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == ST_FDIV && div_start))
        else $error("accepted beat did not start the division chain");

    a_high_speed_needs_period : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[63:48] != 16'd0))
        else $error("high speed flagged with zero frame period");
`endif

endmodule
